// ----- hdl/gbd_pkg.sv -----
package gbd_pkg;

  // Parser phases, one-hot
  typedef enum logic [13:0] {
    PH_HDR   = 14'b00000000000001,
    PH_SCR   = 14'b00000000000010,
    PH_GTAB  = 14'b00000000000100,
    PH_BODY  = 14'b00000000001000,
    PH_LABEL = 14'b00000000010000,
    PH_IDESC = 14'b00000000100000,
    PH_LTAB  = 14'b00000001000000,
    PH_LZW   = 14'b00000010000000,
    PH_DONE  = 14'b00000100000000,
    PH_ERR   = 14'b00001000000000,
    PH_FLEN  = 14'b00010000000000,
    PH_FDAT  = 14'b00100000000000,
    PH_SLEN  = 14'b01000000000000,
    PH_SDAT  = 14'b10000000000000
  } phase_e;

  // Which block the current sub-block chain belongs to
  typedef enum logic [2:0] {
    KIND_GFX = 3'd0,
    KIND_APP = 3'd1,
    KIND_COM = 3'd2,
    KIND_PTX = 3'd3,
    KIND_IMG = 3'd4
  } kind_e;

  // Section codes
  localparam logic [3:0] SEC_HEADER    = 4'd0;
  localparam logic [3:0] SEC_SCREEN    = 4'd1;
  localparam logic [3:0] SEC_GTABLE    = 4'd2;
  localparam logic [3:0] SEC_GFX       = 4'd3;
  localparam logic [3:0] SEC_APP       = 4'd4;
  localparam logic [3:0] SEC_COMMENT   = 4'd5;
  localparam logic [3:0] SEC_PLAINTEXT = 4'd6;
  localparam logic [3:0] SEC_IDESC     = 4'd7;
  localparam logic [3:0] SEC_LTABLE    = 4'd8;
  localparam logic [3:0] SEC_IDATA     = 4'd9;
  localparam logic [3:0] SEC_TRAILER   = 4'd10;
  localparam logic [3:0] SEC_ERROR     = 4'd11;

  // Byte roles
  localparam logic [2:0] ROLE_FIXED = 3'd0;
  localparam logic [2:0] ROLE_INTRO = 3'd1;
  localparam logic [2:0] ROLE_LEN   = 3'd2;
  localparam logic [2:0] ROLE_DATA  = 3'd3;
  localparam logic [2:0] ROLE_TERM  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SIG     = 2'd1;
  localparam logic [1:0] ERR_VERSION = 2'd2;
  localparam logic [1:0] ERR_BLOCK   = 2'd3;

  // Block introducers and extension labels
  localparam logic [7:0] BYTE_EXT     = 8'h21;
  localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
  localparam logic [7:0] BYTE_TRAILER = 8'h3B;
  localparam logic [7:0] LABEL_GFX    = 8'hF9;
  localparam logic [7:0] LABEL_APP    = 8'hFF;
  localparam logic [7:0] LABEL_COM    = 8'hFE;
  localparam logic [7:0] LABEL_PTX    = 8'h01;

  // Packed-field and last byte positions
  localparam logic [9:0] SCR_PACKED_POS = 10'd4;
  localparam logic [9:0] SCR_LAST_POS   = 10'd6;
  localparam logic [9:0] IDESC_LAST_POS = 10'd8;
  localparam logic [9:0] HDR_LAST_POS   = 10'd5;

  typedef struct packed {
    logic       finished;
    logic [1:0] error_code;
    logic [9:0] offset_in_section;
    logic [7:0] byte_echo;
    logic [2:0] role;
    logic [3:0] section;
  } gbd_result_t;

  // Index of the last byte of a color table: 3 << (code + 1), minus one
  function automatic logic [9:0] table_last(input logic [2:0] code);
    logic [9:0] last;
    case (code)
      3'd0:    last = 10'd5;
      3'd1:    last = 10'd11;
      3'd2:    last = 10'd23;
      3'd3:    last = 10'd47;
      3'd4:    last = 10'd95;
      3'd5:    last = 10'd191;
      3'd6:    last = 10'd383;
      default: last = 10'd767;
    endcase
    return last;
  endfunction

  // Section of a sub-block chain by its owner
  function automatic logic [3:0] kind_section(input kind_e kind);
    logic [3:0] sec;
    case (kind)
      KIND_GFX: sec = SEC_GFX;
      KIND_APP: sec = SEC_APP;
      KIND_COM: sec = SEC_COMMENT;
      KIND_PTX: sec = SEC_PLAINTEXT;
      KIND_IMG: sec = SEC_IDATA;
      default:  sec = SEC_ERROR;
    endcase
    return sec;
  endfunction

endpackage

// ----- hdl/gbd_parser.sv -----
module gbd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  output gbd_pkg::gbd_result_t result_o
);
  import gbd_pkg::*;

  phase_e     phase_q, phase_d;
  kind_e      kind_q, kind_d;
  logic [9:0] pos_q, pos_d;
  logic [7:0] left_q, left_d;
  logic [2:0] size_q, size_d;
  logic       present_q, present_d;
  logic [1:0] err_q, err_d;
  logic       done_q, done_d;

  logic [3:0] sec;
  logic [2:0] role;
  logic [9:0] off;
  logic       hdr_ok;
  logic       pkt_present;

  // Check the signature and version byte at the current header position
  always_comb begin
    case (pos_q)
      10'd0:   hdr_ok = (data_byte_i == 8'h47);
      10'd1:   hdr_ok = (data_byte_i == 8'h49);
      10'd2:   hdr_ok = (data_byte_i == 8'h46);
      10'd3:   hdr_ok = (data_byte_i == 8'h38);
      10'd4:   hdr_ok = (data_byte_i == 8'h37) || (data_byte_i == 8'h39);
      default: hdr_ok = (data_byte_i == 8'h61);
    endcase
  end

  // Table flag of the image descriptor's packed byte, seen as it arrives
  assign pkt_present = data_byte_i[7];

  // Tag the byte and work out the next parser state
  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    pos_d     = pos_q;
    left_d    = left_q;
    size_d    = size_q;
    present_d = present_q;
    err_d     = err_q;
    done_d    = done_q;
    sec       = SEC_ERROR;
    role      = ROLE_FIXED;
    off       = '0;

    unique case (phase_q)
      PH_HDR: begin
        sec = SEC_HEADER;
        off = pos_q;
        if (!hdr_ok) begin
          err_d   = (pos_q < 10'd3) ? ERR_SIG : ERR_VERSION;
          phase_d = PH_ERR;
        end else if (pos_q == HDR_LAST_POS) begin
          pos_d   = '0;
          phase_d = PH_SCR;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      PH_SCR: begin
        sec = SEC_SCREEN;
        off = pos_q;
        if (pos_q == SCR_PACKED_POS) begin
          present_d = data_byte_i[7];
          size_d    = data_byte_i[2:0];
        end
        if (pos_q == SCR_LAST_POS) begin
          pos_d   = '0;
          phase_d = present_q ? PH_GTAB : PH_BODY;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      PH_IDESC: begin
        sec = SEC_IDESC;
        off = pos_q;
        if (pos_q == IDESC_LAST_POS) begin
          present_d = pkt_present;
          size_d    = data_byte_i[2:0];
          pos_d     = '0;
          phase_d   = pkt_present ? PH_LTAB : PH_LZW;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      PH_GTAB, PH_LTAB: begin
        sec = (phase_q == PH_GTAB) ? SEC_GTABLE : SEC_LTABLE;
        off = pos_q;
        if (pos_q == table_last(size_q)) begin
          pos_d   = '0;
          phase_d = (phase_q == PH_GTAB) ? PH_BODY : PH_LZW;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      PH_BODY: begin
        role = ROLE_INTRO;
        if (data_byte_i == BYTE_EXT) begin
          sec     = SEC_GFX;
          phase_d = PH_LABEL;
        end else if (data_byte_i == BYTE_IMAGE) begin
          sec     = SEC_IDESC;
          pos_d   = '0;
          phase_d = PH_IDESC;
        end else if (data_byte_i == BYTE_TRAILER) begin
          sec     = SEC_TRAILER;
          done_d  = 1'b1;
          phase_d = PH_DONE;
        end else begin
          err_d   = ERR_BLOCK;
          phase_d = PH_ERR;
        end
      end
      PH_LABEL: begin
        role = ROLE_INTRO;
        if (data_byte_i == LABEL_GFX) begin
          sec     = SEC_GFX;
          kind_d  = KIND_GFX;
          phase_d = PH_FLEN;
        end else if (data_byte_i == LABEL_APP) begin
          sec     = SEC_APP;
          kind_d  = KIND_APP;
          phase_d = PH_FLEN;
        end else if (data_byte_i == LABEL_COM) begin
          sec     = SEC_COMMENT;
          kind_d  = KIND_COM;
          phase_d = PH_SLEN;
        end else if (data_byte_i == LABEL_PTX) begin
          sec     = SEC_PLAINTEXT;
          kind_d  = KIND_PTX;
          phase_d = PH_FLEN;
        end else begin
          err_d   = ERR_BLOCK;
          phase_d = PH_ERR;
        end
      end
      PH_LZW: begin
        sec     = SEC_IDATA;
        kind_d  = KIND_IMG;
        phase_d = PH_SLEN;
      end
      PH_FLEN, PH_SLEN: begin
        sec    = kind_section(kind_q);
        left_d = data_byte_i;
        if (phase_q == PH_FLEN) begin
          pos_d = '0;
        end
        if (data_byte_i == 8'h00) begin
          role    = ROLE_TERM;
          phase_d = PH_BODY;
        end else begin
          role    = ROLE_LEN;
          phase_d = (phase_q == PH_FLEN) ? PH_FDAT : PH_SDAT;
        end
      end
      PH_FDAT: begin
        sec    = kind_section(kind_q);
        off    = pos_q;
        left_d = left_q - 8'd1;
        if (left_q == 8'd1) begin
          pos_d   = '0;
          phase_d = PH_SLEN;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      PH_SDAT: begin
        sec    = kind_section(kind_q);
        role   = ROLE_DATA;
        left_d = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = PH_SLEN;
        end
      end
      PH_DONE: begin
        sec = SEC_TRAILER;
      end
      PH_ERR: begin
        sec = SEC_ERROR;
      end
      default: begin
        phase_d = PH_ERR;
      end
    endcase

    // Report an error byte and all later bytes the same way
    if (phase_d == PH_ERR) begin
      sec  = SEC_ERROR;
      role = ROLE_FIXED;
      off  = '0;
    end
  end

  assign result_o.section           = sec;
  assign result_o.role              = role;
  assign result_o.byte_echo         = data_byte_i;
  assign result_o.offset_in_section = off;
  assign result_o.error_code        = (phase_d == PH_ERR) ? err_d : ERR_NONE;
  assign result_o.finished          = done_d;

  // Advance the parser state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      kind_q    <= KIND_GFX;
      pos_q     <= '0;
      left_q    <= '0;
      size_q    <= '0;
      present_q <= 1'b0;
      err_q     <= ERR_NONE;
      done_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      pos_q     <= pos_d;
      left_q    <= left_d;
      size_q    <= size_d;
      present_q <= present_d;
      err_q     <= err_d;
      done_q    <= done_d;
    end
  end

endmodule

// ----- hdl/gbd_out_stage.sv -----
module gbd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gbd_pkg::gbd_result_t in_result_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gbd_pkg::gbd_result_t out_result_o
);
  import gbd_pkg::*;

  logic        valid_q;
  gbd_result_t result_q;

  // Take a new item whenever the held one is gone or leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= in_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

// ----- hdl/gif_block_deframer.sv -----
// GIF block deframer: feed the file one byte per item on the slave stream and
// get one tagged item per byte on the master stream, telling the section
// (header, screen descriptor, color tables, extensions, image descriptor,
// image data, trailer or error), the role of the byte, its offset within a
// fixed part or color table, an error code and a finished flag. A bad
// signature, bad version or unexpected block byte switches the block into a
// held error state until reset; bytes after the trailer are tagged as trailer.
// One item is accepted per clock cycle while the receiver keeps up: the byte
// is tagged by the parser state machine in the cycle it is accepted, and the
// result sits in a single output register. A new byte is taken in the same
// cycle the held result leaves, so items flow back to back; while the
// receiver holds off, that register stays full and the input side stalls.
module gif_block_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [3:0] section, [6:4] role,
                                        // [14:7] byte_echo,
                                        // [24:15] offset_in_section,
                                        // [26:25] error_code, [27] finished
);
  import gbd_pkg::*;

  logic        accept;
  gbd_result_t tag;
  gbd_result_t held;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  gbd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .result_o    (tag)
  );

  gbd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_result_i  (tag),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (held)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata_o = {4'b0000, held.finished, held.error_code,
                           held.offset_in_section, held.byte_echo,
                           held.role, held.section};

endmodule
